// File: rtl/core/b2da_pkg.sv
// shared constants and types for the binary to decimal ascii converter
package b2da_pkg;

    // input number width used by the converter and digit capacity of the text
    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 20;

    // decimal digits needed for the largest VALUE_BITS number
    localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    localparam int IDX_W    = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;
    localparam int BITCNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    // fixed field widths
    localparam int VALUE_W  = 64;
    localparam int LIMIT_W  = 8;
    localparam int CHAR_W   = 6;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - CHAR_W - POS_W - CNT_W - STATUS_W;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_COMPLETE  = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_NO_ROOM   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_SCAN,
        S_LOAD,
        S_EMIT
    } state_t;

endpackage

// File: rtl/core/binary_to_decimal_ascii.sv
// binary to decimal ascii converter: shift-and-add-3 conversion, then the digits one character at a time
// sequence: double-dabble shifts over all VALUE_BITS (64) bits, a scan from the top digit down to the
//   leading digit and a load state, after which the first character is valid
// requests: one at a time, a new one taken the cycle after the last character is handed off
// reset: rst_n asynchronous active low, clears the sequencer and output valid; digits are not reset
module binary_to_decimal_ascii
(
    input  logic                            clk,
    input  logic                            rst_n,

    // input request
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [b2da_pkg::S_TDATA_W-1:0]  s_tdata,   // value[63:0], max_chars[71:64]

    // output characters
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [b2da_pkg::M_TDATA_W-1:0]  m_tdata,   // char_code[5:0], position[10:6],
                                                       // digit_count[15:11], status[17:16], zero pad
    output logic                            m_tlast,   // last
    output logic                            m_tuser    // char_valid
);

    b2da_pkg::state_t state_reg, state_next;

    // value being shifted out msb first into the bcd digits
    logic [b2da_pkg::VALUE_BITS-1:0] shift_reg, shift_next;
    logic [b2da_pkg::BITCNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [b2da_pkg::LIMIT_W-1:0]    limit_reg, limit_next;

    // decimal digits, least significant first
    logic [3:0] bcd_reg  [b2da_pkg::BCD_DIGITS];
    logic [3:0] bcd_next [b2da_pkg::BCD_DIGITS];
    logic [3:0] bcd_adj  [b2da_pkg::BCD_DIGITS];

    // scan index while finding the length, then index of the next digit to emit
    logic [b2da_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [b2da_pkg::CNT_W-1:0] count_reg, count_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                          out_cvalid_reg, out_cvalid_next;
    logic [b2da_pkg::POS_W-1:0]    out_pos_reg, out_pos_next;
    logic                          out_last_reg, out_last_next;
    logic [b2da_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [3:0]                 rd_digit;
    logic [b2da_pkg::CNT_W-1:0] scan_count;
    logic [b2da_pkg::CNT_W-1:0] emit_w;
    logic                       m_fire;

    assign m_fire = out_valid_reg && m_tready;

    // single read port into the digits
    assign rd_digit   = bcd_reg[idx_reg];
    assign scan_count = b2da_pkg::CNT_W'(idx_reg) + b2da_pkg::CNT_W'(1);

    // emitted length: full length capped by the limit and by digit capacity
    always_comb
    begin
        emit_w = scan_count;
        if ({{(b2da_pkg::LIMIT_W-b2da_pkg::CNT_W){1'b0}}, emit_w} > limit_reg)
        begin
            emit_w = b2da_pkg::CNT_W'(limit_reg);
        end
        if (32'(emit_w) > b2da_pkg::MAX_DIGITS)
        begin
            emit_w = b2da_pkg::CNT_W'(b2da_pkg::MAX_DIGITS);
        end
    end

    // add-3 correction of every digit; S_CONVERT then shifts in the next value bit
    always_comb
    begin
        for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b2da_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg      <= shift_next;
        bit_cnt_reg    <= bit_cnt_next;
        limit_reg      <= limit_next;
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        out_char_reg   <= out_char_next;
        out_cvalid_reg <= out_cvalid_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++)
        begin
            bcd_reg[i] <= bcd_next[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        limit_next      = limit_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_cvalid_next = out_cvalid_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++)
        begin
            bcd_next[i] = bcd_reg[i];
        end
        s_tready = 1'b0;

        case (state_reg)
            b2da_pkg::S_IDLE:
            begin
                // ready is high here, so a valid request is taken
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    shift_next   = s_tdata[b2da_pkg::VALUE_BITS-1:0];
                    limit_next   = s_tdata[b2da_pkg::VALUE_W +: b2da_pkg::LIMIT_W];
                    bit_cnt_next = b2da_pkg::BITCNT_W'(b2da_pkg::VALUE_BITS - 1);
                    for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++)
                    begin
                        bcd_next[i] = 4'd0;
                    end
                    state_next = b2da_pkg::S_CONVERT;
                end
            end

            b2da_pkg::S_CONVERT:
            begin
                bcd_next[0] = {bcd_adj[0][2:0], shift_reg[b2da_pkg::VALUE_BITS-1]};
                for (int i = 1; i < b2da_pkg::BCD_DIGITS; i++)
                begin
                    bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
                end
                shift_next   = shift_reg << 1;
                bit_cnt_next = bit_cnt_reg - b2da_pkg::BITCNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    idx_next   = b2da_pkg::IDX_W'(b2da_pkg::BCD_DIGITS - 1);
                    state_next = b2da_pkg::S_SCAN;
                end
            end

            b2da_pkg::S_SCAN:
            begin
                // walk down from the top digit to the first nonzero one
                if (rd_digit != 4'd0 || idx_reg == '0)
                begin
                    count_next = scan_count;
                    if (limit_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_char_next   = '0;
                        out_cvalid_next = 1'b0;
                        out_pos_next    = '0;
                        out_last_next   = 1'b1;
                        out_status_next = b2da_pkg::STATUS_NO_ROOM;
                        state_next      = b2da_pkg::S_EMIT;
                    end
                    else
                    begin
                        out_status_next = (emit_w != scan_count) ?
                                          b2da_pkg::STATUS_TRUNCATED :
                                          b2da_pkg::STATUS_COMPLETE;
                        idx_next        = b2da_pkg::IDX_W'(emit_w - b2da_pkg::CNT_W'(1));
                        out_pos_next    = '0;
                        state_next      = b2da_pkg::S_LOAD;
                    end
                end
                else
                begin
                    idx_next = idx_reg - b2da_pkg::IDX_W'(1);
                end
            end

            b2da_pkg::S_LOAD:
            begin
                out_valid_next  = 1'b1;
                out_char_next   = b2da_pkg::ASCII_ZERO + {2'b00, rd_digit};
                out_cvalid_next = 1'b1;
                out_last_next   = (idx_reg == '0);
                idx_next        = idx_reg - b2da_pkg::IDX_W'(1);
                state_next      = b2da_pkg::S_EMIT;
            end

            b2da_pkg::S_EMIT:
            begin
                if (m_fire)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = b2da_pkg::S_IDLE;
                    end
                    else
                    begin
                        out_char_next = b2da_pkg::ASCII_ZERO + {2'b00, rd_digit};
                        out_pos_next  = out_pos_reg + b2da_pkg::POS_W'(1);
                        out_last_next = (idx_reg == '0);
                        idx_next      = idx_reg - b2da_pkg::IDX_W'(1);
                    end
                end
            end

            default:
            begin
                out_valid_next = 1'b0;
                state_next     = b2da_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_cvalid_reg;
    assign m_tdata  = {{b2da_pkg::M_PAD_W{1'b0}}, out_status_reg, count_reg,
                       out_pos_reg, out_char_reg};

endmodule

// File: rtl/core/b2da_checker.sv
// port-level checks for the binary to decimal ascii converter
module b2da_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [b2da_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [b2da_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);

    // no new request is taken while a character is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
    else $error("input ready while output pending");

    // a taken request keeps the input closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a request");

    // stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed while stalled");

    // a result with no character is the single no-room result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast &&
            m_tdata[17:16] == b2da_pkg::STATUS_NO_ROOM && m_tdata[10:6] == '0))
    else $error("bad no-room result");

    // a character result carries an ascii digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[5:0] >= b2da_pkg::ASCII_ZERO &&
            m_tdata[5:0] <= b2da_pkg::ASCII_NINE))
    else $error("character out of digit range");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
